FILE: sv/r2h_pkg.sv
// ----------------------------------------------------------------------------
// r2h_pkg
// Shared types, constants and the restoring divide step for the RGB to HSL
// converter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package r2h_pkg;

  // channel geometry
  localparam int CHANNEL_BITS = 8;
  localparam int HUE_BITS     = 9;

  // hue divide needs quotients up to 120, so seven bits
  localparam int HUE_Q_BITS = 7;

  // quotient length shared by both dividers, rounded up to an even count
  localparam int DIV_Q_RAW  = (CHANNEL_BITS > HUE_Q_BITS) ? CHANNEL_BITS : HUE_Q_BITS;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_Q_BITS = ((DIV_Q_RAW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE)
                              * STEPS_PER_STAGE;
  localparam int DIV_STAGES = DIV_Q_BITS / STEPS_PER_STAGE;

  // divisor and partial remainder width (divisors reach 2*full scale)
  localparam int DIV_BITS = CHANNEL_BITS + 1;

  // numerator widths: 2*d*full + den, and 120*(diff+d) + d
  localparam int SAT_NUM_BITS = 2 * CHANNEL_BITS + 2;
  localparam int HUE_NUM_BITS = CHANNEL_BITS + 8;

  // full scale and twice full scale
  localparam logic [CHANNEL_BITS:0] FULL_SCALE = {1'b0, {CHANNEL_BITS{1'b1}}};
  localparam logic [CHANNEL_BITS:0] TWO_FULL   = {{CHANNEL_BITS{1'b1}}, 1'b0};

  // hue offsets per sector after removing the 60 degree bias of the quotient
  localparam logic [HUE_BITS-1:0] HUE_WRAP      = 9'd360;
  localparam logic [HUE_BITS-1:0] HUE_RED_BASE  = 9'd300;
  localparam logic [HUE_BITS-1:0] HUE_RED_SPLIT = 9'd60;
  localparam logic [HUE_BITS-1:0] HUE_GRN_BASE  = 9'd60;
  localparam logic [HUE_BITS-1:0] HUE_BLU_BASE  = 9'd180;

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t opacity_in;
  } pix_t;

  typedef struct packed {
    logic [HUE_BITS-1:0] hue;
    chan_t               saturation;
    chan_t               lightness;
    chan_t               opacity_out;
  } hsl_t;

  // one restoring divider lane: remainder, dividend bits still to shift in
  // (quotient bits shift in from the bottom), divisor
  typedef struct packed {
    logic [DIV_BITS-1:0]   rem;
    logic [DIV_Q_BITS-1:0] low;
    logic [DIV_BITS-1:0]   dvs;
  } lane_t;

  typedef struct packed {
    logic    grey;
    sector_t sector;
    chan_t   lightness;
    chan_t   opacity;
    lane_t   sat;
    lane_t   hue;
  } work_t;

  // one quotient bit of restoring division
  function automatic lane_t lane_step(lane_t x);
    lane_t             y;
    logic [DIV_BITS:0] t;
    logic [DIV_BITS:0] dx;
    y  = x;
    t  = {x.rem, x.low[DIV_Q_BITS-1]};
    dx = {1'b0, x.dvs};
    y.low = {x.low[DIV_Q_BITS-2:0], 1'b0};
    if (t >= dx) begin
      t        = t - dx;
      y.low[0] = 1'b1;
    end
    y.rem = t[DIV_BITS-1:0];
    return y;
  endfunction

endpackage

`default_nettype wire

FILE: sv/r2h_div_stage.sv
// ----------------------------------------------------------------------------
// r2h_div_stage
// One register stage of the two restoring dividers; retires a fixed number
// of quotient bits for saturation and hue per word.
// ----------------------------------------------------------------------------
`default_nettype none

module r2h_div_stage
  import r2h_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  up_valid,
  input  wire work_t up_work,
  output logic       up_ready,
  output logic       dn_valid,
  output work_t      dn_work,
  input  wire logic  dn_ready
);

  work_t work_next;

  // quotient bits for this stage
  always_comb begin
    work_next = up_work;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      work_next.sat = lane_step(work_next.sat);
      work_next.hue = lane_step(work_next.hue);
    end
  end

  // stage loads when empty or when the next stage takes its word
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_work <= work_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rgb_to_hsl_converter_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_unit
// Pipelined RGBA to HSL converter: max/min stage, numerator setup stage,
// radix-2 restoring divider stages for saturation and hue, output register.
// ----------------------------------------------------------------------------
// Path: stage 1, stage 2, the divider stages and the output register lie between pixel
// acceptance and hsl_valid; quotient bits are retired two per divider stage.
// Throughput: one pixel per cycle while the output is not stalled; every stage holds its own
// valid bit and fills bubbles while the output is stalled.
// Reset: synchronous, clears all valid bits; the data registers are not reset.
`default_nettype none

module rgb_to_hsl_converter_unit
  import r2h_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic pixel_valid,
  output logic      pixel_stall,
  input  wire pix_t pixel,
  output logic      hsl_valid,
  input  wire logic hsl_stall,
  output hsl_t      hsl
);

  // ready chain, index k means "divider stage k can take a word"
  logic  dv   [DIV_STAGES+1];
  work_t dw   [DIV_STAGES+1];
  logic  drdy [DIV_STAGES+1];

  logic out_ready;
  logic s1_ready;
  logic s2_ready;

  // stage 1 registers
  logic    s1_valid;
  chan_t   s1_mx;
  chan_t   s1_mn;
  chan_t   s1_pa;
  chan_t   s1_pb;
  sector_t s1_sector;
  chan_t   s1_alpha;

  chan_t   mx_next;
  chan_t   mn_next;
  chan_t   pa_next;
  chan_t   pb_next;
  sector_t sector_next;

  // stage 2 registers
  logic  s2_valid;
  work_t s2_work;
  work_t s2_work_next;

  logic [CHANNEL_BITS:0]   sum_w;
  logic [CHANNEL_BITS-1:0] d_w;
  logic [CHANNEL_BITS+1:0] light_w;
  logic [CHANNEL_BITS:0]   den_full;
  logic [CHANNEL_BITS-1:0] den_w;
  logic [CHANNEL_BITS+1:0] hdiff_w;
  logic [SAT_NUM_BITS-1:0] sat_num;
  logic [SAT_NUM_BITS-1:0] sat_hi;
  logic [HUE_NUM_BITS-1:0] hue_num;
  logic [HUE_NUM_BITS-1:0] hue_hi;

  hsl_t                  hsl_next;
  logic [HUE_BITS-1:0]   hue_q;

  // handshake chain from the output back to the input
  assign out_ready   = !hsl_valid || !hsl_stall;
  assign s2_ready    = !s2_valid || drdy[0];
  assign s1_ready    = !s1_valid || s2_ready;
  assign pixel_stall = !s1_ready;

  // largest channel with red over green over blue on ties, and smallest
  always_comb begin
    if (pixel.red >= pixel.green && pixel.red >= pixel.blue) begin
      sector_next = SEC_RED;
      mx_next     = pixel.red;
      pa_next     = pixel.green;
      pb_next     = pixel.blue;
    end else if (pixel.green >= pixel.blue) begin
      sector_next = SEC_GREEN;
      mx_next     = pixel.green;
      pa_next     = pixel.blue;
      pb_next     = pixel.red;
    end else begin
      sector_next = SEC_BLUE;
      mx_next     = pixel.blue;
      pa_next     = pixel.red;
      pb_next     = pixel.green;
    end
    mn_next = pixel.red;
    if (pixel.green < mn_next) begin
      mn_next = pixel.green;
    end
    if (pixel.blue < mn_next) begin
      mn_next = pixel.blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && pixel_valid) begin
      s1_mx     <= mx_next;
      s1_mn     <= mn_next;
      s1_pa     <= pa_next;
      s1_pb     <= pb_next;
      s1_sector <= sector_next;
      s1_alpha  <= pixel.opacity_in;
    end
  end

  // lightness, denominators and divider numerators
  always_comb begin
    sum_w    = {1'b0, s1_mx} + {1'b0, s1_mn};
    d_w      = s1_mx - s1_mn;
    light_w  = {1'b0, sum_w} + {{(CHANNEL_BITS+1){1'b0}}, 1'b1};
    den_full = (sum_w <= FULL_SCALE) ? sum_w : (TWO_FULL - sum_w);
    den_w    = den_full[CHANNEL_BITS-1:0];

    // 2*d*full + den
    sat_num = (SAT_NUM_BITS'(d_w) << (CHANNEL_BITS + 1)) - (SAT_NUM_BITS'(d_w) << 1)
              + SAT_NUM_BITS'(den_w);
    // 120*(diff + d) + d, never negative
    hdiff_w = (CHANNEL_BITS+2)'(s1_pa) + (CHANNEL_BITS+2)'(d_w)
              - (CHANNEL_BITS+2)'(s1_pb);
    hue_num = (HUE_NUM_BITS'(hdiff_w) << 7) - (HUE_NUM_BITS'(hdiff_w) << 3)
              + HUE_NUM_BITS'(d_w);

    sat_hi = sat_num >> DIV_Q_BITS;
    hue_hi = hue_num >> DIV_Q_BITS;

    s2_work_next.grey      = (d_w == '0);
    s2_work_next.sector    = s1_sector;
    s2_work_next.lightness = light_w[CHANNEL_BITS:1];
    s2_work_next.opacity   = s1_alpha;
    s2_work_next.sat.rem   = sat_hi[DIV_BITS-1:0];
    s2_work_next.sat.low   = sat_num[DIV_Q_BITS-1:0];
    s2_work_next.sat.dvs   = {den_w, 1'b0};
    s2_work_next.hue.rem   = hue_hi[DIV_BITS-1:0];
    s2_work_next.hue.low   = hue_num[DIV_Q_BITS-1:0];
    s2_work_next.hue.dvs   = {d_w, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_work <= s2_work_next;
    end
  end

  // divider stages
  assign dv[0]            = s2_valid;
  assign dw[0]            = s2_work;
  assign drdy[DIV_STAGES] = out_ready;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    r2h_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (dv[k]),
      .up_work  (dw[k]),
      .up_ready (drdy[k]),
      .dn_valid (dv[k+1]),
      .dn_work  (dw[k+1]),
      .dn_ready (drdy[k+1])
    );
  end

  // hue from sector and biased quotient, grey forces zero
  always_comb begin
    hue_q = HUE_BITS'(dw[DIV_STAGES].hue.low[HUE_Q_BITS-1:0]);
    case (dw[DIV_STAGES].sector)
      SEC_RED: begin
        hsl_next.hue = (hue_q < HUE_RED_SPLIT) ? (HUE_RED_BASE + hue_q)
                                               : (hue_q - HUE_RED_SPLIT);
      end
      SEC_GREEN: begin
        hsl_next.hue = HUE_GRN_BASE + hue_q;
      end
      SEC_BLUE: begin
        hsl_next.hue = HUE_BLU_BASE + hue_q;
      end
      default: begin
        hsl_next.hue = '0;
      end
    endcase
    hsl_next.saturation  = dw[DIV_STAGES].sat.low[CHANNEL_BITS-1:0];
    hsl_next.lightness   = dw[DIV_STAGES].lightness;
    hsl_next.opacity_out = dw[DIV_STAGES].opacity;
    if (dw[DIV_STAGES].grey) begin
      hsl_next.hue        = '0;
      hsl_next.saturation = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      hsl_valid <= 1'b0;
    end else if (out_ready) begin
      hsl_valid <= dv[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && dv[DIV_STAGES]) begin
      hsl <= hsl_next;
    end
  end

  // checks
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsl_valid |-> (hsl.hue < HUE_WRAP))
    else $error("hue out of range");

  a_zero_sat_is_grey: assert property (@(posedge clk) disable iff (rst)
    (hsl_valid && hsl.saturation == '0) |-> (hsl.hue == '0))
    else $error("zero saturation with nonzero hue");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_work.grey) |-> (s2_work.sat.dvs != '0 && s2_work.hue.dvs != '0))
    else $error("zero divisor on a colored pixel");

  a_empty_output_takes_input: assert property (@(posedge clk) disable iff (rst)
    !hsl_valid |-> !pixel_stall)
    else $error("input stalled with an empty output register");

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGBA to HSL converter: pixels go in through a
// valid/stall port, every hsl word is compared field by field against an
// in-bench prediction, under three idle/stall mixes plus a long output hold.
// ----------------------------------------------------------------------------

module tb
  import r2h_pkg::*;
();

  localparam int CHAN_MAX         = (1 << CHANNEL_BITS) - 1;
  localparam int RANDOM_PER_PHASE = 250;
  localparam int HOLD_CYCLES      = 120;
  localparam int QUIET_LIMIT      = 3000;
  localparam int TAIL_CYCLES      = 24;

  // expected hsl words, predicted when each pixel is accepted
  class hsl_scoreboard;
    hsl_t expected_hsl[$];
    int   errors;
    int   checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    // exact rational half-up conversion of one pixel
    function hsl_t predict_hsl(pix_t p);
      int   r, g, b, mx, mn, sum, d, den, num, h;
      hsl_t o;
      r  = p.red;
      g  = p.green;
      b  = p.blue;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      sum = mx + mn;
      d   = mx - mn;
      o.lightness   = chan_t'((sum + 1) >> 1);
      o.opacity_out = p.opacity_in;
      if (d == 0) begin
        // grey pixel carries no hue and no saturation
        o.hue        = '0;
        o.saturation = '0;
      end else begin
        den = (sum <= CHAN_MAX) ? sum : 2 * CHAN_MAX - sum;
        o.saturation = chan_t'((2 * d * CHAN_MAX + den) / (2 * den));
        // sector of the largest channel, ties go red, then green
        if (mx == r)
          num = 360 * d + 60 * (g - b);
        else if (mx == g)
          num = 480 * d + 60 * (b - r);
        else
          num = 600 * d + 60 * (r - g);
        h = (2 * num + d) / (2 * d);
        if (h >= 360) h -= 360;
        o.hue = h[HUE_BITS-1:0];
      end
      return o;
    endfunction

    function void note_pixel(pix_t p);
      expected_hsl.push_back(predict_hsl(p));
    endfunction

    function void check_hsl(hsl_t got);
      hsl_t want;
      if (expected_hsl.size() == 0) begin
        $error("hsl word %h arrived with no pixel outstanding", got);
        errors++;
        return;
      end
      want = expected_hsl.pop_front();
      checked++;
      if (got.hue !== want.hue) begin
        $error("hue: expected %0d, got %0d", want.hue, got.hue);
        errors++;
      end
      if (got.saturation !== want.saturation) begin
        $error("saturation: expected %0d, got %0d", want.saturation, got.saturation);
        errors++;
      end
      if (got.lightness !== want.lightness) begin
        $error("lightness: expected %0d, got %0d", want.lightness, got.lightness);
        errors++;
      end
      if (got.opacity_out !== want.opacity_out) begin
        $error("opacity_out: expected %0d, got %0d", want.opacity_out, got.opacity_out);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst         = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  pix_t pixel       = '0;
  logic hsl_valid;
  logic hsl_stall   = 1'b0;
  hsl_t hsl;

  hsl_scoreboard sb;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int holds_done     = 0;
  int pixels_in      = 0;
  int quiet_cycles   = 0;

  rgb_to_hsl_converter_unit uut (
    .clk        (clk),
    .rst        (rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel      (pixel),
    .hsl_valid  (hsl_valid),
    .hsl_stall  (hsl_stall),
    .hsl        (hsl)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // handshake monitor: notes pixels, checks hsl words, counts quiet cycles
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_valid && !pixel_stall) begin
        sb.note_pixel(pixel);
        pixels_in++;
      end
      if (hsl_valid && !hsl_stall)
        sb.check_hsl(hsl);
      if ((pixel_valid && !pixel_stall) || (hsl_valid && !hsl_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // watchdog
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("rgb_to_hsl_converter_unit: mismatch");
    $finish;
  end

  // output side: random stall, or a long hold when one is requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        hsl_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) begin
          @(negedge clk);
          hsl_stall <= 1'b1;
        end
      end else begin
        hsl_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic pix_t mk_px(int r, int g, int b, int a);
    pix_t p;
    p.red        = chan_t'(r);
    p.green      = chan_t'(g);
    p.blue       = chan_t'(b);
    p.opacity_in = chan_t'(a);
    return p;
  endfunction

  // random pixel, biased toward greys, tied maxima and saturated corners
  function automatic pix_t random_pixel();
    pix_t p;
    chan_t v;
    p = pix_t'($urandom());
    v = chan_t'($urandom());
    case ($urandom_range(9))
      0: begin
        p.red   = v;
        p.green = v;
        p.blue  = v;
      end
      1: begin
        p.red   = v;
        p.green = v;
        p.blue  = chan_t'($urandom_range(int'(v)));
      end
      2: begin
        p.green = v;
        p.blue  = v;
        p.red   = chan_t'($urandom_range(int'(v)));
      end
      3: begin
        p.red   = $urandom_range(1) ? chan_t'(CHAN_MAX) : '0;
        p.green = $urandom_range(1) ? chan_t'(CHAN_MAX) : '0;
      end
      default: ;
    endcase
    return p;
  endfunction

  // offer one pixel, called and returning at a falling edge
  task automatic send_pixel(input pix_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      pixel       <= pix_t'($urandom());
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering until every outstanding word has come back
  task automatic drain();
    pixel_valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_hsl.size() != 0) @(negedge clk);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_pixel(random_pixel());
  endtask

  initial begin
    sb = new();
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // phase 1: sender mostly busy, receiver mostly stalled
    send_idle_pct  = 12;
    recv_stall_pct = 86;

    // corners and special cases
    send_pixel(mk_px(0, 0, 0, 0));
    send_pixel(mk_px(255, 255, 255, 255));
    send_pixel(mk_px(255, 0, 0, 8'hA5));
    send_pixel(mk_px(0, 255, 0, 8'h5A));
    send_pixel(mk_px(0, 0, 255, 8'h0F));
    send_pixel(mk_px(255, 255, 0, 8'hF0));
    send_pixel(mk_px(0, 255, 255, 1));
    send_pixel(mk_px(255, 0, 255, 254));
    send_pixel(mk_px(128, 128, 128, 128));
    // hue just under 360 rounds up and wraps to zero
    send_pixel(mk_px(255, 0, 1, 127));
    // negative hue wraps
    send_pixel(mk_px(255, 0, 3, 3));
    send_pixel(mk_px(1, 0, 0, 200));
    send_pixel(mk_px(254, 255, 255, 55));
    // saturation denominator split around full scale
    send_pixel(mk_px(128, 127, 127, 9));
    send_pixel(mk_px(129, 127, 127, 10));
    send_pixel(mk_px(255, 254, 254, 11));
    send_pixel(mk_px(170, 85, 51, 8'hAA));
    send_pixel(mk_px(85, 170, 255, 8'h55));
    send_pixel(mk_px(0, 1, 0, 64));
    send_pixel(mk_px(0, 0, 1, 32));
    send_pixel(mk_px(200, 100, 150, 16));
    send_random(RANDOM_PER_PHASE);
    drain();

    // phase 2: sender mostly idle, receiver mostly ready
    send_idle_pct  = 86;
    recv_stall_pct = 12;
    send_random(RANDOM_PER_PHASE);
    drain();

    // phase 3: no idling, with one long output hold to back up the pipe
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    send_random(RANDOM_PER_PHASE);
    drain();

    repeat (TAIL_CYCLES) @(negedge clk);

    $display("%0d pixels in, %0d hsl words checked, %0d field errors", pixels_in,
             sb.checked, sb.errors);
    $display("covered corners, greys, tied maxima, hue wrap, idle/stall mixes and a full stall");
    if (sb.errors == 0) begin
      $display("rgb_to_hsl_converter_unit: match");
    end else begin
      $display("rgb_to_hsl_converter_unit: mismatch");
    end
    $finish;
  end

endmodule
